@@ rtl/damped_drop_pulse_detector_macros.svh @@
// assertion macros for the damped drop pulse detector
// expects clk and rst_n in the scope of each use
`ifndef DAMPED_DROP_PULSE_DETECTOR_MACROS_SVH
`define DAMPED_DROP_PULSE_DETECTOR_MACROS_SVH

// same-cycle implication, off during reset
`define DDPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DDPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ddpd_pkg.sv @@
// constants and types for the damped drop pulse detector
// no dependencies
`default_nettype none

package ddpd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 32;

  localparam int FRAC_EXTRA = 8;
  localparam int DAMP_WIDTH = 17;
  localparam int DAMP_SHIFT = 16;

  localparam logic [DAMP_WIDTH-1:0] ONE_Q16 = 17'd65536;

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;

  localparam logic [DAMP_WIDTH-1:0] DAMPING_RST     = 17'd62259;
  localparam logic [31:0]           MIN_SPACING_RST = 32'd75000;

  typedef enum logic [1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_MIN_SPACING = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

@@ rtl/damped_drop_pulse_detector.sv @@
// damped drop pulse detector: smoothed level, drop delta, spaced edge hits
// depends on ddpd_pkg and damped_drop_pulse_detector_macros.svh
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_stall  | sample_value, timestamp
//   out_     | output    | out_valid / out_stall| hit, drop_delta
//   apb      | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one item per cycle sustained while out_stall is low; a result passes the input register, then the result register
// the level feedback loop (one multiply and add) sits between the input register
// and the result register, state updates when an item moves into the result register
// reset is synchronous, active low; level, edge and hit history clear to zero
// a stalled result holds; the input register still takes one more item behind it
`default_nettype none
`include "damped_drop_pulse_detector_macros.svh"

module damped_drop_pulse_detector
  import ddpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,

  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [SAMPLE_WIDTH-1:0]    in_sample_value,
  input  wire         [TIME_WIDTH-1:0]      in_timestamp,

  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              out_hit,
  output logic signed [SAMPLE_WIDTH:0]      out_drop_delta,

  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire         [APB_ADDR_WIDTH-1:0]  paddr,
  input  wire         [APB_DATA_WIDTH-1:0]  pwdata,
  output logic        [APB_DATA_WIDTH-1:0]  prdata,
  output logic                              pready
);

  localparam int LW = SAMPLE_WIDTH + FRAC_EXTRA;
  localparam int DW = SAMPLE_WIDTH + 1;
  localparam int PW = LW + DAMP_WIDTH + 2;

  // configuration
  logic signed [DW-1:0]         threshold_r;
  logic        [DAMP_WIDTH-1:0] damping_r;
  logic        [TIME_WIDTH-1:0] min_spacing_r;
  logic                         cfg_wr;
  reg_idx_t                     cfg_idx;

  // input register
  logic                           s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic        [TIME_WIDTH-1:0]   s1_time_r;

  // detector state
  logic signed [LW-1:0]         level_r, level_nxt;
  logic                         over_prev_r;
  logic        [TIME_WIDTH-1:0] last_hit_r, last_hit_nxt;
  logic                         hit_seen_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic signed [DW-1:0] out_delta_r;

  logic                         adv;
  logic                         in_xfer;
  logic        [DAMP_WIDTH-1:0] damp_eff;
  logic signed [LW-1:0]         sample_q16;
  logic signed [LW:0]           diff;
  logic signed [PW-1:0]         diff_ext;
  logic signed [PW-1:0]         damp_ext;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         scaled;
  logic signed [DW-1:0]         delta;
  logic                         over;
  logic                         rise;
  logic        [TIME_WIDTH-1:0] last_eff;
  logic        [TIME_WIDTH-1:0] gap;
  logic                         gate_open;
  logic                         hit_c;

  // handshake
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD:   prdata = APB_DATA_WIDTH'(threshold_r);
      REG_DAMPING:     prdata = APB_DATA_WIDTH'(damping_r);
      REG_MIN_SPACING: prdata = APB_DATA_WIDTH'(min_spacing_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= '0;
      damping_r     <= DAMPING_RST;
      min_spacing_r <= TIME_WIDTH'(MIN_SPACING_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD:   threshold_r   <= DW'($signed(pwdata));
        REG_DAMPING:     damping_r     <= pwdata[DAMP_WIDTH-1:0];
        REG_MIN_SPACING: min_spacing_r <= TIME_WIDTH'(pwdata);
        default: ;
      endcase
    end
  end

  // level update and drop delta
  assign damp_eff   = (damping_r > ONE_Q16) ? ONE_Q16 : damping_r;
  assign sample_q16 = {s1_sample_r, {FRAC_EXTRA{1'b0}}};
  assign diff       = $signed({level_r[LW-1], level_r}) -
                      $signed({sample_q16[LW-1], sample_q16});
  assign diff_ext   = PW'(diff);
  assign damp_ext   = $signed(PW'({1'b0, damp_eff}));
  assign prod       = diff_ext * damp_ext;
  assign scaled     = prod >>> DAMP_SHIFT;
  assign level_nxt  = LW'(scaled) + sample_q16;

  assign delta = $signed({level_r[LW-1], level_r[LW-1:FRAC_EXTRA]}) -
                 $signed({s1_sample_r[SAMPLE_WIDTH-1], s1_sample_r});
  assign over  = delta > threshold_r;
  assign rise  = over && !over_prev_r;

  // spacing gate
  assign last_eff     = (hit_seen_r && (s1_time_r < last_hit_r)) ? '0 : last_hit_r;
  assign gap          = s1_time_r - last_eff;
  assign gate_open    = !hit_seen_r || (gap >= min_spacing_r);
  assign hit_c        = rise && gate_open;
  assign last_hit_nxt = hit_c ? s1_time_r : last_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      over_prev_r <= 1'b0;
      last_hit_r  <= '0;
      hit_seen_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        level_r     <= level_nxt;
        over_prev_r <= over;
        last_hit_r  <= last_hit_nxt;
        hit_seen_r  <= hit_seen_r || hit_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample_value;
      s1_time_r   <= in_timestamp;
    end
    if (adv) begin
      out_hit_r   <= hit_c;
      out_delta_r <= delta;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_drop_delta = out_delta_r;

  `DDPD_ASSERT_NOW(a_stall_only_when_full, in_stall,
    s1_valid_r && out_valid_r && out_stall, "input stalled with room in the pipeline")
  `DDPD_ASSERT_NEXT(a_hit_records_time, adv && hit_c,
    last_hit_r == $past(s1_time_r), "hit did not record its timestamp")
  `DDPD_ASSERT_NEXT(a_hit_seen_sticks, hit_seen_r,
    hit_seen_r, "hit history cleared outside reset")
  `DDPD_ASSERT_NOW(a_out_hit_seen, out_valid_r && out_hit_r,
    hit_seen_r, "hit shown without hit history")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// testbench for damped_drop_pulse_detector: directed and random sample streams,
// checked against an in-bench model of the damped level and spaced hit logic
// depends on ddpd_pkg and the rtl top level
`timescale 1ns / 100ps

module tb
  import ddpd_pkg::*;
();

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic               hit;
    logic signed [16:0] delta;
  } drop_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample_value = '0;
  logic [31:0]        in_timestamp = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic signed [16:0] out_drop_delta;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  damped_drop_pulse_detector u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_drop_delta  (out_drop_delta),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // model registers and state
  logic signed [16:0] threshold_q8 = '0;
  logic [16:0]        damping_q16 = DAMPING_RST;
  logic [31:0]        spacing_ticks = MIN_SPACING_RST;
  logic signed [23:0] level_q16 = '0;
  bit                 was_over = 1'b0;
  logic [31:0]        last_hit_time = '0;
  bit                 any_hit = 1'b0;

  drop_result_t pending_results[$];
  int           n_errors = 0;
  int           n_samples = 0;
  int           n_hits = 0;
  int           n_writes = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic drop_result_t detect_drop(input logic signed [15:0] smp,
                                               input logic [31:0] now);
    longint       lvl, s16, dmp, prod, dlt, thr;
    bit           over, rising;
    drop_result_t r;
    lvl = level_q16;
    s16 = longint'(smp) * 256;
    thr = threshold_q8;
    if (damping_q16 > ONE_Q16) dmp = 65536;
    else dmp = damping_q16;
    if (any_hit && now < last_hit_time) last_hit_time = '0;
    dlt = (lvl >>> 8) - longint'(smp);
    prod = (lvl - s16) * dmp;
    level_q16 = 24'(s16 + (prod >>> 16));
    over = dlt > thr;
    rising = over && !was_over;
    was_over = over;
    r.hit = 1'b0;
    if (rising && (!any_hit || (now - last_hit_time) >= spacing_ticks)) begin
      r.hit = 1'b1;
      any_hit = 1'b1;
      last_hit_time = now;
    end
    r.delta = dlt[16:0];
    return r;
  endfunction

  // result side: random stall and compare
  always @(posedge clk) begin
    drop_result_t want;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (out_hit === 1'b1) n_hits++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: hit %0d, drop_delta %0d",
               out_hit, out_drop_delta);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          n_errors++;
        end
        if (out_drop_delta !== want.delta) begin
          $error("drop_delta: expected %0d, got %0d", $signed(want.delta), out_drop_delta);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_sample(input int smp, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= 16'(smp);
    in_timestamp <= now;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(detect_drop(16'(smp), now));
    n_samples++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] rd_want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: begin
        threshold_q8 = value[16:0];
        rd_want = 32'(threshold_q8);
      end
      REG_DAMPING: begin
        damping_q16 = value[16:0];
        rd_want = 32'(damping_q16);
      end
      REG_MIN_SPACING: begin
        spacing_ticks = value;
        rd_want = value;
      end
      default: rd_want = '0;
    endcase
    if (prdata !== rd_want) begin
      $error("prdata: expected %0h, got %0h", rd_want, prdata);
      n_errors++;
    end
    n_writes++;
  endtask

  // reset defaults: first drop always hits, later edges gated by default spacing
  task automatic test_first_hit();
    send_sample(-256, 32'd10);
    send_sample(-256, 32'd20);
    send_sample(0, 32'd30);
    send_sample(-512, 32'd40);
  endtask

  task automatic test_field_extremes();
    wait_for_results();
    cfg_write(REG_THRESHOLD, 32'(-65535));
    cfg_write(REG_MIN_SPACING, 32'd0);
    send_sample(32767, 32'd0);
    send_sample(-32768, 32'hffff_ffff);
    send_sample(32767, 32'd1);
    send_sample(-32768, 32'hffff_ffff);
    wait_for_results();
    cfg_write(REG_THRESHOLD, 32'd65535);
    send_sample(32767, 32'h8000_0000);
    send_sample(-32768, 32'h8000_0001);
    send_sample(-32768, 32'h7fff_ffff);
  endtask

  // held level, then time jumps back below the earlier timestamps
  task automatic test_time_backwards();
    wait_for_results();
    cfg_write(REG_DAMPING, 32'd65536);
    cfg_write(REG_THRESHOLD, 32'd256);
    cfg_write(REG_MIN_SPACING, 32'd100);
    send_sample(-512, 32'd1000);
    send_sample(0, 32'd1010);
    send_sample(-512, 32'd50);
    send_sample(0, 32'd60);
    send_sample(-512, 32'd200);
  endtask

  task automatic test_damping_limits();
    wait_for_results();
    cfg_write(REG_DAMPING, 32'd0);
    send_sample(1000, 32'd300);
    send_sample(-1000, 32'd400);
    wait_for_results();
    cfg_write(REG_DAMPING, 32'h1ffff);
    send_sample(-20000, 32'd500);
    send_sample(20000, 32'd600);
  endtask

  task automatic test_random_phase(input int idle_in, input int idle_out, input int n_items);
    int          base, smp, r;
    logic [31:0] now;
    wait_for_results();
    case ($urandom_range(4))
      0: cfg_write(REG_THRESHOLD, 32'(-65535));
      1: cfg_write(REG_THRESHOLD, 32'd65535);
      2: cfg_write(REG_THRESHOLD, 32'(int'($urandom_range(131070)) - 65535));
      default: cfg_write(REG_THRESHOLD, 32'($urandom_range(3000)));
    endcase
    case ($urandom_range(5))
      0: cfg_write(REG_DAMPING, 32'd0);
      1: cfg_write(REG_DAMPING, 32'd65536);
      2: cfg_write(REG_DAMPING, 32'($urandom_range(131071, 65537)));
      3: cfg_write(REG_DAMPING, 32'(DAMPING_RST));
      default: cfg_write(REG_DAMPING, 32'($urandom_range(65535, 50000)));
    endcase
    case ($urandom_range(4))
      0: cfg_write(REG_MIN_SPACING, 32'd0);
      1: cfg_write(REG_MIN_SPACING, 32'hffff_ffff);
      default: cfg_write(REG_MIN_SPACING, 32'($urandom_range(2000)));
    endcase
    send_idle_pct = idle_in;
    stall_pct = idle_out;
    base = int'($urandom_range(65535)) - 32768;
    now = $urandom();
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 5) base = int'($urandom_range(65535)) - 32768;
      if (r < 12) smp = int'($urandom_range(65535)) - 32768;
      else if (r < 30) smp = base - int'($urandom_range(4000));
      else smp = base + int'($urandom_range(64)) - 32;
      if (smp > 32767) smp = 32767;
      if (smp < -32768) smp = -32768;
      r = $urandom_range(99);
      if (r < 3) now = $urandom();
      else if (r < 6) now = now - $urandom_range(500);
      else now = now + $urandom_range(400);
      send_sample(smp, now);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_hit();
    test_field_extremes();
    test_time_backwards();
    test_damping_limits();
    for (int k = 0; k < 2; k++) begin
      test_random_phase(0, 0, 100);
      test_random_phase(85, 0, 100);
      test_random_phase(0, 85, 100);
      test_random_phase(15, 15, 100);
    end
    wait_for_results();
    repeat (6) @(posedge clk);
    $display("covered %0d samples (%0d hits) over %0d register writes,", n_samples, n_hits,
             n_writes);
    $display("with free-running, sparse-input, heavy-stall and mixed traffic");
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
